[hw/rtl/bwm_pkg.sv]
// shared types and constants of the battery warning manager
`timescale 1ns / 1ps
package bwm_pkg;

  // one battery sample
  typedef struct packed {
    logic [30:0] time_s;
    logic [6:0]  percent;
    logic [1:0]  ac_status;
    logic        charging;
    logic        have_info;
    logic        init_request;
    logic        updated;
  } in_item_t;

  // one status message
  typedef struct packed {
    logic [3:0] msg_code;
    logic [6:0] shown_percent;
    logic       play_alarm;
    logic       manager_disabled;
    logic       last_of_run;
  } out_item_t;

  // configuration register file contents
  typedef struct packed {
    logic [15:0] startup_wait_s;
    logic [15:0] check_interval_s;
    logic [15:0] critical_retry_s;
    logic [15:0] very_low_retry_s;
    logic [4:0]  warn_limit;
    logic [15:0] warn_quiet_s;
  } cfg_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_WAIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK_IVL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CRIT_RETRY   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VLOW_RETRY   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WARN_QUIET   = 3'd5;

  localparam logic [15:0] RST_STARTUP_WAIT = 16'd30;
  localparam logic [15:0] RST_CHECK_IVL    = 16'd300;
  localparam logic [15:0] RST_CRIT_RETRY   = 16'd60;
  localparam logic [15:0] RST_VLOW_RETRY   = 16'd120;
  localparam logic [4:0]  RST_WARN_LIMIT   = 5'd15;
  localparam logic [15:0] RST_WARN_QUIET   = 16'd3600;

  // message codes
  localparam logic [3:0] MSG_LEVEL    = 4'd0;
  localparam logic [3:0] MSG_DISABLED = 4'd1;
  localparam logic [3:0] MSG_SUP_OFF  = 4'd2;
  localparam logic [3:0] MSG_SUP_ON   = 4'd3;
  localparam logic [3:0] MSG_BACKUP   = 4'd4;
  localparam logic [3:0] MSG_RECHARGE = 4'd5;
  localparam logic [3:0] MSG_FULL     = 4'd6;
  localparam logic [3:0] MSG_CRITICAL = 4'd7;
  localparam logic [3:0] MSG_VERY_LOW = 4'd8;
  localparam logic [3:0] MSG_LOW      = 4'd9;
  localparam logic [3:0] MSG_MUTED    = 4'd10;

  // supply status codes
  localparam logic [1:0] SUP_OFF     = 2'd0;
  localparam logic [1:0] SUP_ON      = 2'd1;
  localparam logic [1:0] SUP_BACKUP  = 2'd2;
  localparam logic [1:0] SUP_UNKNOWN = 2'd3;

  // charge thresholds
  localparam logic [6:0] PCT_FULL  = 7'd100;
  localparam logic [6:0] PCT_HALF  = 7'd50;
  localparam logic [6:0] PCT_WARN  = 7'd30;
  localparam logic [6:0] PCT_LOW   = 7'd20;
  localparam logic [6:0] PCT_VLOW  = 7'd10;
  localparam logic [6:0] PCT_CRIT  = 7'd5;

endpackage

[hw/rtl/bwm_cfg.sv]
// configuration register file
`timescale 1ns / 1ps
module bwm_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [bwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bwm_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output bwm_pkg::cfg_t              cfg
);
  import bwm_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.startup_wait_s   <= RST_STARTUP_WAIT;
      cfg_r.check_interval_s <= RST_CHECK_IVL;
      cfg_r.critical_retry_s <= RST_CRIT_RETRY;
      cfg_r.very_low_retry_s <= RST_VLOW_RETRY;
      cfg_r.warn_limit       <= RST_WARN_LIMIT;
      cfg_r.warn_quiet_s     <= RST_WARN_QUIET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STARTUP_WAIT: cfg_r.startup_wait_s   <= cfg_wdata;
        CFG_CHECK_IVL:    cfg_r.check_interval_s <= cfg_wdata;
        CFG_CRIT_RETRY:   cfg_r.critical_retry_s <= cfg_wdata;
        CFG_VLOW_RETRY:   cfg_r.very_low_retry_s <= cfg_wdata;
        CFG_WARN_LIMIT:   cfg_r.warn_limit       <= cfg_wdata[4:0];
        CFG_WARN_QUIET:   cfg_r.warn_quiet_s     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[hw/rtl/bwm_ctrl.sv]
// manager state and per-sample message decision
`timescale 1ns / 1ps
module bwm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  bwm_pkg::cfg_t       cfg,
  input  bwm_pkg::in_item_t   item,
  input  logic                commit,
  output logic [1:0]          res_cnt,
  output bwm_pkg::out_item_t  res0,
  output bwm_pkg::out_item_t  res1
);
  import bwm_pkg::*;

  typedef struct packed {
    logic        ok;
    logic        mute_msg;
    logic [4:0]  wc;
    logic        mu;
    logic [30:0] lwt;
  } warn_res_t;

  // rate limiter for supply, recharge and full messages
  function automatic warn_res_t give_warn(input logic [30:0] t, input logic [4:0] wc,
                                          input logic mu, input logic [30:0] lwt,
                                          input cfg_t c);
    warn_res_t r;
    r.ok       = 1'b0;
    r.mute_msg = 1'b0;
    r.wc       = wc;
    r.mu       = mu;
    r.lwt      = lwt;
    if ({1'b0, t} > ({1'b0, lwt} + {16'b0, c.warn_quiet_s})) begin
      r.mu = 1'b0;
      r.wc = 5'd0;
    end
    if (!r.mu) begin
      if (r.wc >= c.warn_limit) begin
        r.mute_msg = 1'b1;
        r.mu       = 1'b1;
      end else begin
        r.wc  = r.wc + 5'd1;
        r.lwt = t;
        r.ok  = 1'b1;
      end
    end
    return r;
  endfunction

  // next check pulled forward so a retry fires after the retry time, capped at the full interval
  function automatic logic signed [32:0] retry_base(input logic [30:0] t,
                                                    input logic [15:0] retry,
                                                    input logic [15:0] ivl);
    logic [15:0] r;
    r = (retry > ivl) ? ivl : retry;
    return $signed({2'b00, t}) - $signed({17'b0, ivl - r});
  endfunction

  logic               dis_r, dis_nxt;
  logic               rch_r, rch_nxt;
  logic               a30_r, a30_nxt;
  logic               a50_r, a50_nxt;
  logic               a100_r, a100_nxt;
  logic signed [32:0] lct_r, lct_nxt;
  logic [30:0]        st_r, st_nxt;
  logic [6:0]         lvl_r, lvl_nxt;
  logic [1:0]         sup_r, sup_nxt;
  logic [4:0]         wc_r, wc_nxt;
  logic               mu_r, mu_nxt;
  logic [30:0]        lwt_r, lwt_nxt;

  logic               a_vld, b_vld, b_alarm, start_ok;
  logic [3:0]         a_code, b_code;
  logic [6:0]         a_pct, b_pct;
  warn_res_t          w1, w2;
  logic signed [33:0] t_s, due_s;
  logic [30:0]        t;
  logic [6:0]         pct;
  logic [1:0]         sts;

  assign t   = item.time_s;
  assign pct = item.percent;
  assign sts = item.ac_status;

  always_comb begin
    dis_nxt  = dis_r;
    rch_nxt  = rch_r;
    a30_nxt  = a30_r;
    a50_nxt  = a50_r;
    a100_nxt = a100_r;
    lct_nxt  = lct_r;
    st_nxt   = st_r;
    lvl_nxt  = lvl_r;
    sup_nxt  = sup_r;
    wc_nxt   = wc_r;
    mu_nxt   = mu_r;
    lwt_nxt  = lwt_r;
    a_vld    = 1'b0;
    a_code   = MSG_LEVEL;
    a_pct    = 7'd0;
    b_vld    = 1'b0;
    b_code   = MSG_LEVEL;
    b_pct    = 7'd0;
    b_alarm  = 1'b0;
    start_ok = 1'b1;
    w1       = '0;
    w2       = '0;
    t_s      = $signed({3'b000, t});
    due_s    = '0;

    if (item.updated && !dis_r) begin
      if (item.init_request) begin
        dis_nxt  = 1'b0;
        rch_nxt  = 1'b0;
        a30_nxt  = 1'b1;
        a50_nxt  = 1'b1;
        a100_nxt = 1'b1;
        lct_nxt  = '0;
        st_nxt   = '0;
        lvl_nxt  = '0;
        sup_nxt  = SUP_OFF;
        wc_nxt   = '0;
        if (!item.have_info || pct == 7'd0 || pct > PCT_FULL) begin
          dis_nxt  = 1'b1;
          start_ok = 1'b0;
        end else begin
          st_nxt = t;
        end
      end

      if (start_ok) begin
        if (lvl_nxt == 7'd0) begin
          // first level check after the startup wait
          if ({1'b0, t} >= ({1'b0, st_nxt} + {16'b0, cfg.startup_wait_s})) begin
            if (pct <= PCT_HALF) begin
              lct_nxt = $signed({2'b00, t});
              a_vld   = 1'b1;
              a_code  = MSG_LEVEL;
              a_pct   = pct;
              a50_nxt = 1'b0;
            end
            if (pct == 7'd0) begin
              b_vld   = 1'b1;
              b_code  = MSG_DISABLED;
              dis_nxt = 1'b1;
            end else begin
              lvl_nxt = pct;
              if (sts != SUP_UNKNOWN) begin
                sup_nxt = sts;
              end
            end
          end
        end else begin
          if (sts != SUP_UNKNOWN) begin
            if (sup_nxt != sts) begin
              w1      = give_warn(t, wc_nxt, mu_nxt, lwt_nxt, cfg);
              wc_nxt  = w1.wc;
              mu_nxt  = w1.mu;
              lwt_nxt = w1.lwt;
              if (w1.ok) begin
                a_vld = 1'b1;
                case (sts)
                  SUP_OFF: a_code = MSG_SUP_OFF;
                  SUP_ON:  a_code = MSG_SUP_ON;
                  default: a_code = MSG_BACKUP;
                endcase
              end else if (w1.mute_msg) begin
                a_vld  = 1'b1;
                a_code = MSG_MUTED;
              end
            end
            sup_nxt = sts;
          end

          due_s = $signed({lct_nxt[32], lct_nxt}) + $signed({18'b0, cfg.check_interval_s});
          if (t_s >= due_s) begin
            if (lvl_nxt < pct) begin
              // charge rising
              a30_nxt  = 1'b1;
              a50_nxt  = 1'b1;
              a100_nxt = 1'b1;
              lvl_nxt  = pct;
              if (!rch_nxt) begin
                rch_nxt = 1'b1;
                if (item.charging || sts == SUP_ON) begin
                  w2      = give_warn(t, wc_nxt, mu_nxt, lwt_nxt, cfg);
                  wc_nxt  = w2.wc;
                  mu_nxt  = w2.mu;
                  lwt_nxt = w2.lwt;
                  b_vld   = w2.ok | w2.mute_msg;
                  b_code  = w2.ok ? MSG_RECHARGE : MSG_MUTED;
                  lct_nxt = $signed({2'b00, t});
                end
              end
            end else if (lvl_nxt == pct) begin
              if (rch_nxt && pct == PCT_FULL && a100_nxt) begin
                w2       = give_warn(t, wc_nxt, mu_nxt, lwt_nxt, cfg);
                wc_nxt   = w2.wc;
                mu_nxt   = w2.mu;
                lwt_nxt  = w2.lwt;
                b_vld    = w2.ok | w2.mute_msg;
                b_code   = w2.ok ? MSG_FULL : MSG_MUTED;
                a100_nxt = 1'b0;
                lct_nxt  = $signed({2'b00, t});
              end
            end else begin
              // charge falling
              rch_nxt = 1'b0;
              if (pct <= PCT_CRIT) begin
                b_vld   = 1'b1;
                b_code  = MSG_CRITICAL;
                b_pct   = pct;
                b_alarm = 1'b1;
                lct_nxt = retry_base(t, cfg.critical_retry_s, cfg.check_interval_s);
                lvl_nxt = pct;
              end else if (pct <= PCT_VLOW) begin
                b_vld   = 1'b1;
                b_code  = MSG_VERY_LOW;
                b_pct   = pct;
                lct_nxt = retry_base(t, cfg.very_low_retry_s, cfg.check_interval_s);
                lvl_nxt = pct;
              end else if (pct <= PCT_LOW) begin
                b_vld   = 1'b1;
                b_code  = MSG_LOW;
                b_pct   = pct;
                lct_nxt = $signed({2'b00, t});
                lvl_nxt = pct;
              end else if (pct <= PCT_WARN) begin
                if (a30_nxt) begin
                  b_vld   = 1'b1;
                  b_code  = MSG_LEVEL;
                  b_pct   = pct;
                  a30_nxt = 1'b0;
                end
                lct_nxt = $signed({2'b00, t});
                lvl_nxt = pct;
              end else if (pct <= PCT_HALF) begin
                a50_nxt = 1'b0;
                lct_nxt = $signed({2'b00, t});
                lvl_nxt = pct;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dis_r  <= 1'b0;
      rch_r  <= 1'b0;
      a30_r  <= 1'b1;
      a50_r  <= 1'b1;
      a100_r <= 1'b1;
      lct_r  <= '0;
      st_r   <= '0;
      lvl_r  <= '0;
      sup_r  <= SUP_OFF;
      wc_r   <= '0;
      mu_r   <= 1'b0;
      lwt_r  <= '0;
    end else if (commit) begin
      dis_r  <= dis_nxt;
      rch_r  <= rch_nxt;
      a30_r  <= a30_nxt;
      a50_r  <= a50_nxt;
      a100_r <= a100_nxt;
      lct_r  <= lct_nxt;
      st_r   <= st_nxt;
      lvl_r  <= lvl_nxt;
      sup_r  <= sup_nxt;
      wc_r   <= wc_nxt;
      mu_r   <= mu_nxt;
      lwt_r  <= lwt_nxt;
    end
  end

  // compact the two message slots
  always_comb begin
    res_cnt = {1'b0, a_vld} + {1'b0, b_vld};

    res0.msg_code         = a_vld ? a_code : b_code;
    res0.shown_percent    = a_vld ? a_pct : b_pct;
    res0.play_alarm       = a_vld ? 1'b0 : b_alarm;
    res0.manager_disabled = dis_nxt;
    res0.last_of_run      = !(a_vld && b_vld);

    res1.msg_code         = b_code;
    res1.shown_percent    = b_pct;
    res1.play_alarm       = b_alarm;
    res1.manager_disabled = dis_nxt;
    res1.last_of_run      = 1'b1;
  end

endmodule

[hw/rtl/bwm_outq.sv]
// two-entry result queue
`timescale 1ns / 1ps
module bwm_outq (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  logic [1:0]          push_cnt,
  input  bwm_pkg::out_item_t  push0,
  input  bwm_pkg::out_item_t  push1,
  output logic                has_room,
  output logic                out_valid,
  input  logic                out_ready,
  output bwm_pkg::out_item_t  out_item
);
  import bwm_pkg::*;

  out_item_t  q0_r, q1_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop, load;

  assign pop      = (cnt_r != 2'd0) && out_ready;
  // room for a full pair only once the queue drains this cycle
  assign has_room = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign load     = push && (push_cnt != 2'd0) && has_room;

  always_comb begin
    cnt_nxt = cnt_r - {1'b0, pop};
    if (load) begin
      cnt_nxt = push_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q0_r <= push0;
      q1_r <= push1;
    end else if (pop) begin
      q0_r <= q1_r;
    end
  end

  assign out_valid = (cnt_r != 2'd0);
  assign out_item  = q0_r;

endmodule

[hw/rtl/battery_warning_manager_core.sv]
// top level of the battery warning manager
//
//   port group  | dir | handshake           | payload
//   in_*        | in  | in_valid/in_ready   | in_item  (bwm_pkg::in_item_t)
//   out_*       | out | out_valid/out_ready | out_item (bwm_pkg::out_item_t)
//   cfg_*       | in  | cfg_we, no wait     | cfg_index, cfg_wdata
//
// a sample is registered on accept and evaluated from the input register; its results
// land in the result queue at the edge where it commits, and the queue offers the
// first of them from its head register
// the queue drains one result per cycle while out_ready is high; a sample with
// results commits only once the queue empties, a sample without results at once
// reset (rst_n low, synchronous) clears the manager state and loads the default
// configuration; a stalled result queue holds the pending sample in the input
// register, and a new request is taken whenever that register frees up
`timescale 1ns / 1ps
module battery_warning_manager_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  bwm_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output bwm_pkg::out_item_t             out_item,
  input  logic                           cfg_we,
  input  logic [bwm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bwm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bwm_pkg::*;

  cfg_t       cfg;
  in_item_t   in_item_r;
  logic       in_vld_r;
  logic       fire;
  logic       has_room;
  logic [1:0] res_cnt;
  out_item_t  res0, res1;

  bwm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // held request is evaluated once its results fit in the queue
  assign fire     = in_vld_r && (has_room || (res_cnt == 2'd0));
  assign in_ready = !in_vld_r || fire;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_item_r <= in_item;
    end
  end

  // state update and message decision
  bwm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .item    (in_item_r),
    .commit  (fire),
    .res_cnt (res_cnt),
    .res0    (res0),
    .res1    (res1)
  );

  // results wait here for the consumer
  bwm_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fire),
    .push_cnt  (res_cnt),
    .push0     (res0),
    .push1     (res1),
    .has_room  (has_room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

[verif/battery_warning_manager_core_test.sv]
// self-checking testbench of the battery warning manager core
`timescale 1ns / 1ps
module battery_warning_manager_core_test;
  import bwm_pkg::*;

  // clock and synchronous active-low reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  // block ports, the inputs driven to known values from time zero
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_item_t              in_item = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_item;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  battery_warning_manager_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // -------------------------------------------------------------------------
  // predictor: own copy of the configuration and of the manager state
  // -------------------------------------------------------------------------

  // configuration as last written (reset values until then)
  logic [15:0] startup_wait = RST_STARTUP_WAIT;
  logic [15:0] check_ivl    = RST_CHECK_IVL;
  logic [15:0] crit_retry   = RST_CRIT_RETRY;
  logic [15:0] vlow_retry   = RST_VLOW_RETRY;
  logic [4:0]  warn_cap     = RST_WARN_LIMIT;
  logic [15:0] quiet_win    = RST_WARN_QUIET;

  // manager state
  logic               mgr_off;
  logic               recharging;
  logic               arm30, arm50, arm100;
  logic signed [32:0] chk_t;        // last check time, may lie below zero
  logic [30:0]        start_t;
  logic [6:0]         level;
  logic [1:0]         supply;
  logic [4:0]         warn_cnt;
  logic               muted;
  logic [30:0]        last_warn_t;

  // messages raised by the sample under evaluation
  out_item_t run_msgs [2];
  int        run_len;

  // messages still owed by the block, oldest first
  out_item_t msg_forecast [$];

  // bookkeeping
  in_item_t sample_queue [$];
  int pushed = 0;
  int samples_taken = 0;
  int fed_count = 0;
  int msgs_checked = 0;
  int muted_seen = 0;
  int alarm_seen = 0;
  int settings_used = 0;
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic req_taken = 1'b0;

  function automatic void post_msg(input logic [3:0] code, input logic [6:0] pct,
                                   input logic alarm);
    out_item_t m;
    m = '0;
    m.msg_code = code;
    m.shown_percent = pct;
    m.play_alarm = alarm;
    // a sample never raises more than two messages
    if (run_len < 2) begin
      run_msgs[run_len] = m;
      run_len++;
    end
  endfunction

  // rate limiter in front of supply, recharge and full messages
  function automatic bit warning_allowed(input logic [30:0] t);
    if (longint'(t) > longint'(last_warn_t) + longint'(quiet_win)) begin
      muted = 1'b0;
      warn_cnt = '0;
    end
    if (muted) return 1'b0;
    if (warn_cnt >= warn_cap) begin
      post_msg(MSG_MUTED, '0, 1'b0);
      muted = 1'b1;
      return 1'b0;
    end
    warn_cnt = warn_cnt + 5'd1;
    last_warn_t = t;
    return 1'b1;
  endfunction

  // start request wipes the manager but keeps the mute flag and warning time
  function automatic void clear_mgr();
    mgr_off = 1'b0;
    recharging = 1'b0;
    arm30 = 1'b1;
    arm50 = 1'b1;
    arm100 = 1'b1;
    chk_t = '0;
    start_t = '0;
    level = '0;
    supply = SUP_OFF;
    warn_cnt = '0;
  endfunction

  // pull the next check earlier so the warning repeats after the retry time, capped at the check interval
  function automatic logic signed [32:0] retry_point(input logic [30:0] t,
                                                    input logic [15:0] retry);
    logic [15:0] r;
    r = (retry > check_ivl) ? check_ivl : retry;
    return 33'(longint'(t) - longint'(check_ivl - r));
  endfunction

  function automatic void judge_sample(input in_item_t s);
    logic [30:0] t;
    logic [6:0]  pct;
    logic [1:0]  st;
    t = s.time_s;
    pct = s.percent;
    st = s.ac_status;
    if (s.init_request) begin
      clear_mgr();
      // bad start shuts the manager off without a word
      if (!s.have_info || pct < 7'd1 || pct > PCT_FULL) begin
        mgr_off = 1'b1;
        return;
      end
      start_t = t;
    end
    // first level check, after the startup wait
    if (level == 7'd0) begin
      if (longint'(t) < longint'(start_t) + longint'(startup_wait)) return;
      if (pct <= PCT_HALF) begin
        chk_t = {2'b00, t};
        post_msg(MSG_LEVEL, pct, 1'b0);
        arm50 = 1'b0;
      end
      if (pct == 7'd0) begin
        post_msg(MSG_DISABLED, '0, 1'b0);
        mgr_off = 1'b1;
        return;
      end
      level = pct;
      if (st != SUP_UNKNOWN) supply = st;
      return;
    end
    // supply change, whenever it happens
    if (st != SUP_UNKNOWN) begin
      if (supply != st) begin
        if (warning_allowed(t)) begin
          post_msg((st == SUP_OFF) ? MSG_SUP_OFF : ((st == SUP_ON) ? MSG_SUP_ON : MSG_BACKUP),
                   '0, 1'b0);
        end
      end
      supply = st;
    end
    if (longint'(t) < longint'(chk_t) + longint'(check_ivl)) return;
    // rising charge
    if (level < pct) begin
      arm30 = 1'b1;
      arm50 = 1'b1;
      arm100 = 1'b1;
      level = pct;
      if (!recharging) begin
        recharging = 1'b1;
        if (s.charging || st == SUP_ON) begin
          if (warning_allowed(t)) post_msg(MSG_RECHARGE, '0, 1'b0);
          chk_t = {2'b00, t};
        end
      end
      return;
    end
    // steady charge: full once per recharge
    if (level == pct) begin
      if (recharging && pct == PCT_FULL && arm100) begin
        if (warning_allowed(t)) post_msg(MSG_FULL, '0, 1'b0);
        arm100 = 1'b0;
        chk_t = {2'b00, t};
      end
      return;
    end
    // falling charge
    recharging = 1'b0;
    if (pct <= PCT_CRIT) begin
      post_msg(MSG_CRITICAL, pct, 1'b1);
      chk_t = retry_point(t, crit_retry);
    end else if (pct <= PCT_VLOW) begin
      post_msg(MSG_VERY_LOW, pct, 1'b0);
      chk_t = retry_point(t, vlow_retry);
    end else if (pct <= PCT_LOW) begin
      post_msg(MSG_LOW, pct, 1'b0);
      chk_t = {2'b00, t};
    end else if (pct <= PCT_WARN) begin
      if (arm30) begin
        post_msg(MSG_LEVEL, pct, 1'b0);
        arm30 = 1'b0;
      end
      chk_t = {2'b00, t};
    end else if (pct <= PCT_HALF) begin
      arm50 = 1'b0;
      chk_t = {2'b00, t};
    end else begin
      // above half: nothing, level kept
      return;
    end
    level = pct;
  endfunction

  // work out the messages of one taken request and queue them
  function automatic void forecast_sample(input in_item_t s);
    int k;
    run_len = 0;
    if (!s.updated || mgr_off) return;
    judge_sample(s);
    for (k = 0; k < run_len; k++) begin
      run_msgs[k].manager_disabled = mgr_off;
      run_msgs[k].last_of_run = (k == run_len - 1);
      msg_forecast.push_back(run_msgs[k]);
    end
  endfunction

  // -------------------------------------------------------------------------
  // checking
  // -------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 40) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  task automatic check_msg(input out_item_t got);
    out_item_t want;
    if (msg_forecast.size() == 0) begin
      report_mismatch($sformatf("message code %0d with none expected", got.msg_code));
      return;
    end
    want = msg_forecast.pop_front();
    msgs_checked++;
    if (want.msg_code == MSG_MUTED) muted_seen++;
    if (want.play_alarm) alarm_seen++;
    if (got.msg_code !== want.msg_code)
      report_mismatch($sformatf("msg_code %0d, expected %0d", got.msg_code, want.msg_code));
    if (got.shown_percent !== want.shown_percent)
      report_mismatch($sformatf("shown_percent %0d, expected %0d (code %0d)",
                                got.shown_percent, want.shown_percent, want.msg_code));
    if (got.play_alarm !== want.play_alarm)
      report_mismatch($sformatf("play_alarm %b, expected %b (code %0d)",
                                got.play_alarm, want.play_alarm, want.msg_code));
    if (got.manager_disabled !== want.manager_disabled)
      report_mismatch($sformatf("manager_disabled %b, expected %b (code %0d)",
                                got.manager_disabled, want.manager_disabled, want.msg_code));
    if (got.last_of_run !== want.last_of_run)
      report_mismatch($sformatf("last_of_run %b, expected %b (code %0d)",
                                got.last_of_run, want.last_of_run, want.msg_code));
  endtask

  // monitor: requests and messages sampled at the rising edge
  // prediction goes first so a same-edge message would still find its entry
  always @(posedge clk) begin
    req_taken <= in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        forecast_sample(in_item);
        samples_taken++;
      end
      if (out_valid && out_ready) check_msg(out_item);
    end
  end

  // driver: one request at a time from the queue, changed at the falling edge
  // valid holds with a steady payload until the request is taken
  always @(negedge clk) begin
    if (!in_valid || req_taken) begin
      if (sample_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_item  <= sample_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // -------------------------------------------------------------------------
  // stimulus helpers
  // -------------------------------------------------------------------------

  task automatic queue_sample(input logic [30:0] t, input logic [6:0] pct,
                              input logic [1:0] st, input logic chg, input logic info,
                              input logic init, input logic upd);
    in_item_t s;
    s.time_s = t;
    s.percent = pct;
    s.ac_status = st;
    s.charging = chg;
    s.have_info = info;
    s.init_request = init;
    s.updated = upd;
    sample_queue.push_back(s);
    pushed++;
    // ignored samples do not count toward the stimulus length
    if (upd) fed_count++;
  endtask

  // wait for every request taken and every message in, then let the pipe settle
  task automatic wait_drained();
    do @(negedge clk); while (samples_taken != pushed || msg_forecast.size() != 0);
    repeat (10) @(negedge clk);
  endtask

  // plain register write, mirrored into the predictor while the block is idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_STARTUP_WAIT: startup_wait = val;
      CFG_CHECK_IVL:    check_ivl = val;
      CFG_CRIT_RETRY:   crit_retry = val;
      CFG_VLOW_RETRY:   vlow_retry = val;
      CFG_WARN_LIMIT:   warn_cap = val[4:0];
      CFG_WARN_QUIET:   quiet_win = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [15:0] wait_s, input logic [15:0] ivl,
                               input logic [15:0] crit, input logic [15:0] vlow,
                               input logic [4:0] lim, input logic [15:0] quiet);
    write_reg(CFG_STARTUP_WAIT, wait_s);
    write_reg(CFG_CHECK_IVL, ivl);
    write_reg(CFG_CRIT_RETRY, crit);
    write_reg(CFG_VLOW_RETRY, vlow);
    write_reg(CFG_WARN_LIMIT, {11'd0, lim});
    write_reg(CFG_WARN_QUIET, quiet);
    settings_used++;
  endtask

  // hand-picked walk through the manager with the reset configuration
  task automatic directed_samples();
    // not updated: ignored whatever it says
    queue_sample(31'd5, 7'd50, SUP_OFF, 1'b0, 1'b1, 1'b0, 1'b0);
    // no start ever: acts as started at time zero, still inside the startup wait
    queue_sample(31'd0, 7'd80, SUP_ON, 1'b0, 1'b1, 1'b0, 1'b1);
    queue_sample(31'd30, 7'd80, SUP_ON, 1'b0, 1'b0, 1'b0, 1'b1);
    // supply off, backup, unknown
    queue_sample(31'd40, 7'd80, SUP_OFF, 1'b0, 1'b1, 1'b0, 1'b1);
    queue_sample(31'd50, 7'd80, SUP_BACKUP, 1'b0, 1'b1, 1'b0, 1'b1);
    queue_sample(31'd60, 7'd80, SUP_UNKNOWN, 1'b0, 1'b1, 1'b0, 1'b1);
    // supply on plus recharging in one sample
    queue_sample(31'd400, 7'd90, SUP_ON, 1'b1, 1'b1, 1'b0, 1'b1);
    // falling charge above half: silent
    queue_sample(31'd700, 7'd85, SUP_ON, 1'b0, 1'b1, 1'b0, 1'b1);
    // valid start at full charge, one second short of the wait, then the first check
    queue_sample(31'd1000, 7'd100, SUP_ON, 1'b0, 1'b1, 1'b1, 1'b1);
    queue_sample(31'd1029, 7'd99, SUP_ON, 1'b0, 1'b1, 1'b0, 1'b1);
    queue_sample(31'd1030, 7'd99, SUP_ON, 1'b0, 1'b1, 1'b0, 1'b1);
    // recharging via supply on, then fully charged
    queue_sample(31'd1330, 7'd100, SUP_ON, 1'b0, 1'b1, 1'b0, 1'b1);
    queue_sample(31'd1630, 7'd100, SUP_ON, 1'b1, 1'b1, 1'b0, 1'b1);
    // discharge through every band
    queue_sample(31'd1930, 7'd45, SUP_OFF, 1'b0, 1'b1, 1'b0, 1'b1);
    queue_sample(31'd2230, 7'd28, SUP_OFF, 1'b0, 1'b1, 1'b0, 1'b1);
    queue_sample(31'd2530, 7'd25, SUP_OFF, 1'b0, 1'b1, 1'b0, 1'b1);
    queue_sample(31'd2830, 7'd15, SUP_OFF, 1'b0, 1'b1, 1'b0, 1'b1);
    queue_sample(31'd3130, 7'd8, SUP_OFF, 1'b0, 1'b1, 1'b0, 1'b1);
    queue_sample(31'd3250, 7'd4, SUP_OFF, 1'b0, 1'b1, 1'b0, 1'b1);
    // critical at zero charge after the first check does not disable
    queue_sample(31'd3310, 7'd0, SUP_OFF, 1'b0, 1'b1, 1'b0, 1'b1);
    queue_sample(31'd3400, 7'd127, SUP_ON, 1'b1, 1'b1, 1'b0, 1'b1);
    // latest possible time
    queue_sample(31'h7FFF_FFFF, 7'd126, SUP_OFF, 1'b0, 1'b1, 1'b0, 1'b1);
    // time going back with a start at the lowest valid charge
    queue_sample(31'd3700, 7'd1, SUP_BACKUP, 1'b0, 1'b1, 1'b1, 1'b1);
    queue_sample(31'd3730, 7'd1, SUP_OFF, 1'b0, 1'b1, 1'b0, 1'b1);
    queue_sample(31'd4030, 7'd1, SUP_ON, 1'b0, 1'b1, 1'b0, 1'b1);
  endtask

  // one start request followed by a drifting charge trace
  // charge never reaches zero here: that would shut the manager for good
  task automatic random_session(input int n);
    longint     tt;
    int         lvl, r, k, ci;
    logic [1:0] st;
    logic       up, chg;
    logic [6:0] shown;
    ci = int'(check_ivl);
    tt = longint'($urandom_range(0, 32'h7F00_0000));
    r = $urandom_range(0, 9);
    if (r == 0) lvl = 1;
    else if (r == 1) lvl = 100;
    else lvl = $urandom_range(1, 100);
    st = 2'($urandom_range(0, 3));
    up = 1'($urandom_range(0, 1));
    queue_sample(31'(tt), 7'(lvl), st, up, 1'b1, 1'b1, 1'b1);
    for (k = 0; k < n; k++) begin
      // time step: mostly past the wait or interval, sometimes tiny or backward
      r = $urandom_range(0, 99);
      if (k == 0 && r < 80) tt += startup_wait + $urandom_range(0, ci);
      else if (r < 15) tt += $urandom_range(0, 3);
      else if (r < 55) tt += $urandom_range(1, ci);
      else if (r < 96) tt += $urandom_range(ci, 2 * ci);
      else tt -= $urandom_range(0, 2 * ci);
      if (tt < 0) tt = 0;
      // charge trend flips now and then
      if ($urandom_range(0, 9) == 0) up = ~up;
      if (up) lvl += $urandom_range(0, 12);
      else lvl -= $urandom_range(0, 9);
      if (lvl < 1) lvl = 1;
      if (lvl > 100) lvl = 100;
      if ($urandom_range(0, 3) == 0) st = 2'($urandom_range(0, 3));
      else if (up && $urandom_range(0, 3) == 0) st = SUP_ON;
      chg = up ? ($urandom_range(0, 5) != 0) : ($urandom_range(0, 9) == 0);
      shown = ($urandom_range(0, 19) == 0) ? 7'($urandom_range(101, 127)) : 7'(lvl);
      r = $urandom_range(0, 99);
      if (r < 4) begin
        // not updated: any content, even a bad start, is ignored
        queue_sample(31'(tt), 7'($urandom_range(0, 127)), 2'($urandom_range(0, 3)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'b0);
      end else if (r < 7) begin
        // restart mid trace
        lvl = $urandom_range(1, 100);
        queue_sample(31'(tt), 7'(lvl), st, chg, 1'b1, 1'b1, 1'b1);
      end else begin
        queue_sample(31'(tt), shown, st, chg, ($urandom_range(0, 9) != 0), 1'b0, 1'b1);
      end
    end
  endtask

  // the manager is shut off for good, by a bad start or a dead battery at the
  // first check; only one can happen per run, so the seed picks it
  task automatic disable_for_good();
    logic [30:0] t;
    int k;
    t = 31'($urandom_range(0, 32'h7000_0000));
    case ($urandom_range(0, 3))
      0: queue_sample(t, 7'($urandom_range(1, 100)), SUP_ON, 1'b0, 1'b0, 1'b1, 1'b1);
      1: queue_sample(t, 7'd0, SUP_OFF, 1'b0, 1'b1, 1'b1, 1'b1);
      2: queue_sample(t, 7'($urandom_range(101, 127)), SUP_ON, 1'b1, 1'b1, 1'b1, 1'b1);
      default: begin
        queue_sample(t, 7'd60, SUP_ON, 1'b1, 1'b1, 1'b1, 1'b1);
        queue_sample(t + 31'(startup_wait), 7'd0, SUP_OFF, 1'b0, 1'b1, 1'b0, 1'b1);
      end
    endcase
    // afterwards even a valid start stays silent
    for (k = 0; k < 6; k++) begin
      t = t + 31'($urandom_range(0, 70000));
      queue_sample(t, 7'($urandom_range(1, 100)), 2'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)), 1'b1, (k == 2), 1'b1);
    end
  endtask

  // -------------------------------------------------------------------------
  // test sequence
  // -------------------------------------------------------------------------
  initial begin
    int ph, goal, ci, random_start;
    clear_mgr();
    muted = 1'b0;
    last_warn_t = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    directed_samples();
    wait_drained();
    random_start = fed_count;

    for (ph = 0; ph < 8; ph++) begin
      // idling mode cycles: none, sender idle, receiver stall, both
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      // phase 0 keeps the reset configuration
      case (ph)
        0: ;
        1: apply_setting(16'd0, 16'd1, 16'd0, 16'd0, 5'd1, 16'd0);
        2: apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 5'd31, 16'hFFFF);
        4: apply_setting(16'($urandom_range(0, 20)), 16'($urandom_range(5, 60)),
                         16'($urandom_range(0, 120)), 16'($urandom_range(0, 120)),
                         5'($urandom_range(1, 4)), 16'($urandom_range(0, 300)));
        default: begin
          ci = ($urandom_range(0, 1) != 0) ? $urandom_range(1, 600) : $urandom_range(1, 65535);
          apply_setting(16'($urandom_range(0, 300)), 16'(ci),
                        16'($urandom_range(0, (2 * ci > 65535) ? 65535 : 2 * ci)),
                        16'($urandom_range(0, (2 * ci > 65535) ? 65535 : 2 * ci)),
                        ($urandom_range(0, 1) != 0) ? 5'($urandom_range(1, 4))
                                                    : 5'($urandom_range(1, 31)),
                        16'($urandom_range(0, 3000)));
        end
      endcase
      goal = fed_count + 120;
      while (fed_count < goal) random_session($urandom_range(10, 40));
      wait_drained();
    end

    disable_for_good();
    wait_drained();

    if (msg_forecast.size() != 0)
      report_mismatch($sformatf("%0d expected messages never came", msg_forecast.size()));
    $display("run covered %0d samples (%0d random) and %0d messages over %0d written settings",
             samples_taken, fed_count - random_start, msgs_checked, settings_used);
    $display("among them %0d muted notices and %0d critical alarms", muted_seen, alarm_seen);
    if (errors == 0) begin
      $display("PASS battery_warning_manager_core");
    end else begin
      $display("FAIL battery_warning_manager_core");
    end
    $finish;
  end

  // watchdog far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("FAIL battery_warning_manager_core");
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/bwm_pkg.sv
hw/rtl/bwm_cfg.sv
hw/rtl/bwm_ctrl.sv
hw/rtl/bwm_outq.sv
hw/rtl/battery_warning_manager_core.sv
verif/battery_warning_manager_core_test.sv
